// ===== hdl/tpti_pkg.sv =====
// shared constants, codes and types of the triangular pair/triple index map
`default_nettype none

package tpti_pkg;

   // sizing
   localparam int MAX_POINTS  = 1024;
   localparam int TABLE_DEPTH = MAX_POINTS - 2;
   localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CFG_W       = 11;
   localparam int PNT_W       = 10;
   localparam int DATA_W      = 32;
   localparam int OP_W        = 2;
   localparam int STAT_W      = 2;
   localparam int PT_W        = $clog2(MAX_POINTS + 1);
   localparam int IDX_W       = $clog2(MAX_POINTS);
   localparam int PAIR_W      = $clog2(MAX_POINTS * (MAX_POINTS - 1) / 2 + 1);
   localparam int X_W         = PAIR_W + 3;
   localparam int SQ_W        = X_W + (X_W % 2);
   localparam int SQ_STEPS    = SQ_W / 2;
   localparam int STEP_W      = $clog2(SQ_STEPS);
   localparam int ALU_W       = DATA_W + 1;

   localparam logic [CFG_W-1:0] POINT_COUNT_RESET = 11'd1024;

   // request opcodes
   localparam logic [OP_W-1:0] OP_PAIR   = 2'd0;
   localparam logic [OP_W-1:0] OP_TRIPLE = 2'd1;
   localparam logic [OP_W-1:0] OP_INDEX  = 2'd2;
   localparam logic [OP_W-1:0] OP_WRITE  = 2'd3;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EQUAL = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

   // shared unit operations
   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_SUBB,
      ALU_TRI
   } alu_op_type;

   typedef struct packed {
      alu_op_type       op;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] y;
      logic             neg;
   } alu_rsp_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_BS_RD,
      ST_BS_CMP,
      ST_BASE,
      ST_TOT,
      ST_CHK,
      ST_SQRT,
      ST_TRI,
      ST_PDEC,
      ST_E1,
      ST_E2,
      ST_E3,
      ST_E4,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [DATA_W-1:0] linear_index;
      logic [PNT_W-1:0]  first_point;
      logic [PNT_W-1:0]  second_point;
      logic [PNT_W-1:0]  table_slot;
      logic [DATA_W-1:0] table_value;
   } req_type;

   typedef struct packed {
      logic [PNT_W-1:0]  out_first;
      logic [PNT_W-1:0]  out_second;
      logic [PNT_W-1:0]  out_third;
      logic [DATA_W-1:0] out_index;
      logic [STAT_W-1:0] status;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hdl/tpti_req_if.sv =====
// request channel interface
`default_nettype none

interface tpti_req_if;
   logic                        valid;
   logic                        ready;
   logic [tpti_pkg::OP_W-1:0]   opcode;
   logic [tpti_pkg::DATA_W-1:0] linear_index;
   logic [tpti_pkg::PNT_W-1:0]  first_point;
   logic [tpti_pkg::PNT_W-1:0]  second_point;
   logic [tpti_pkg::PNT_W-1:0]  table_slot;
   logic [tpti_pkg::DATA_W-1:0] table_value;

   modport source (
      output valid, opcode, linear_index, first_point, second_point, table_slot,
             table_value,
      input  ready
   );

   modport sink (
      input  valid, opcode, linear_index, first_point, second_point, table_slot,
             table_value,
      output ready
   );
endinterface

`default_nettype wire

// ===== hdl/tpti_rsp_if.sv =====
// response channel interface
`default_nettype none

interface tpti_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tpti_pkg::PNT_W-1:0]  out_first;
   logic [tpti_pkg::PNT_W-1:0]  out_second;
   logic [tpti_pkg::PNT_W-1:0]  out_third;
   logic [tpti_pkg::DATA_W-1:0] out_index;
   logic [tpti_pkg::STAT_W-1:0] status;

   modport source (
      output valid, out_first, out_second, out_third, out_index, status,
      input  ready
   );

   modport sink (
      input  valid, out_first, out_second, out_third, out_index, status,
      output ready
   );
endinterface

`default_nettype wire

// ===== hdl/tpti_table.sv =====
// running triple count table, one write and one registered read port
`default_nettype none

module tpti_table (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [tpti_pkg::TBL_AW-1:0] wr_addr,
   input  logic [tpti_pkg::DATA_W-1:0] wr_data,
   input  logic [tpti_pkg::TBL_AW-1:0] rd_addr,
   output logic [tpti_pkg::DATA_W-1:0] rd_data
);

   logic [tpti_pkg::DATA_W-1:0] mem [tpti_pkg::TABLE_DEPTH];
   logic [tpti_pkg::DATA_W-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/tpti_alu.sv =====
// shared arithmetic unit: add, subtract with borrow out, triangular number
`default_nettype none

module tpti_alu (
   input  tpti_pkg::alu_req_type alu_req,
   output tpti_pkg::alu_rsp_type alu_rsp
);

   logic                              borrow_in;
   logic [tpti_pkg::ALU_W:0]          diff;
   logic [tpti_pkg::PT_W:0]           tri_v;
   logic [tpti_pkg::PT_W:0]           tri_v1;
   logic [2*tpti_pkg::PT_W+1:0]       tri_prod;

   // subtract with optional extra borrow
   assign borrow_in = (alu_req.op == tpti_pkg::ALU_SUBB);
   assign diff = {1'b0, alu_req.a} - {1'b0, alu_req.b}
                 - {{tpti_pkg::ALU_W{1'b0}}, borrow_in};

   // v * (v + 1) / 2
   assign tri_v    = {1'b0, alu_req.a[tpti_pkg::PT_W-1:0]};
   assign tri_v1   = tri_v + {{tpti_pkg::PT_W{1'b0}}, 1'b1};
   assign tri_prod = {{(tpti_pkg::PT_W+1){1'b0}}, tri_v}
                     * {{(tpti_pkg::PT_W+1){1'b0}}, tri_v1};

   // result select
   always_comb begin
      alu_rsp.y   = '0;
      alu_rsp.neg = 1'b0;
      unique case (alu_req.op) inside
         tpti_pkg::ALU_ADD: begin
            alu_rsp.y = alu_req.a + alu_req.b;
         end
         tpti_pkg::ALU_SUB, tpti_pkg::ALU_SUBB: begin
            alu_rsp.y   = diff[tpti_pkg::ALU_W-1:0];
            alu_rsp.neg = diff[tpti_pkg::ALU_W];
         end
         tpti_pkg::ALU_TRI: begin
            alu_rsp.y = tpti_pkg::ALU_W'(tri_prod >> 1);
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/tpti_core.sv =====
// sequencer and working registers around the shared unit and the count table
`default_nettype none

module tpti_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [tpti_pkg::CFG_W-1:0] point_count,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  tpti_pkg::req_type          in_item,
   output logic                       out_valid,
   input  logic                       out_ready,
   output tpti_pkg::rsp_type          out_item
);

   tpti_pkg::state_type               state_ff, state_in;
   logic [tpti_pkg::OP_W-1:0]         op_ff, op_in;
   logic [tpti_pkg::DATA_W-1:0]       k_ff, k_in;
   logic [tpti_pkg::PNT_W-1:0]        pi_ff, pi_in;
   logic [tpti_pkg::PNT_W-1:0]        pj_ff, pj_in;
   logic [tpti_pkg::PNT_W-1:0]        slot_ff, slot_in;
   logic [tpti_pkg::DATA_W-1:0]       value_ff, value_in;
   logic [tpti_pkg::IDX_W-1:0]        lo_ff, lo_in;
   logic [tpti_pkg::IDX_W-1:0]        hi_ff, hi_in;
   logic [tpti_pkg::IDX_W-1:0]        mid_ff, mid_in;
   logic [tpti_pkg::PT_W-1:0]         dn_ff, dn_in;
   logic [tpti_pkg::DATA_W-1:0]       dk_ff, dk_in;
   logic [tpti_pkg::PAIR_W-1:0]       total_ff, total_in;
   logic [tpti_pkg::PAIR_W-1:0]       tri_ff, tri_in;
   logic [tpti_pkg::PAIR_W-1:0]       rest_ff, rest_in;
   logic [tpti_pkg::SQ_W-1:0]         x_ff, x_in;
   logic [tpti_pkg::SQ_W-1:0]         root_ff, root_in;
   logic [tpti_pkg::SQ_W-1:0]         bit_ff, bit_in;
   logic [tpti_pkg::PT_W-1:0]         o_ff, o_in;
   logic [tpti_pkg::STEP_W-1:0]       step_ff, step_in;
   tpti_pkg::rsp_type                 res_ff, res_in;
   tpti_pkg::rsp_type                 out_ff, out_in;
   logic                              out_valid_ff, out_valid_in;

   logic                              n_ok;
   logic [tpti_pkg::PT_W-1:0]         nn;
   logic [tpti_pkg::PNT_W-1:0]        pt_lo;
   logic [tpti_pkg::PNT_W-1:0]        pt_hi;
   logic [tpti_pkg::IDX_W:0]          mid_sum;
   logic [tpti_pkg::IDX_W-1:0]        mid;
   logic [tpti_pkg::SQ_W-1:0]         sq_trial;
   logic [tpti_pkg::PT_W-1:0]         o_dec;
   logic [tpti_pkg::PT_W-1:0]         p_dec;
   logic [tpti_pkg::PNT_W-1:0]        near_pt;
   logic [tpti_pkg::PNT_W-1:0]        far_pt;

   logic                              tbl_wr_en;
   logic [tpti_pkg::TBL_AW-1:0]       tbl_rd_addr;
   logic [tpti_pkg::DATA_W-1:0]       tbl_rd_data;
   tpti_pkg::alu_req_type             alu_req;
   tpti_pkg::alu_rsp_type             alu_rsp;

   // count table
   tpti_table u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tpti_pkg::TBL_AW'(slot_ff)),
      .wr_data (value_ff),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   // shared arithmetic unit
   tpti_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   // helper terms
   assign n_ok = (32'(point_count) >= 32'd2)
                 && (32'(point_count) <= 32'(tpti_pkg::MAX_POINTS));
   assign nn       = tpti_pkg::PT_W'(point_count);
   assign pt_lo    = (pi_ff < pj_ff) ? pi_ff : pj_ff;
   assign pt_hi    = (pi_ff < pj_ff) ? pj_ff : pi_ff;
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid      = mid_sum[tpti_pkg::IDX_W:1];
   assign sq_trial = root_ff + bit_ff;
   assign o_dec    = tpti_pkg::PT_W'((root_ff - tpti_pkg::SQ_W'(1)) >> 1);
   assign p_dec    = tpti_pkg::PT_W'(alu_rsp.y);
   assign near_pt  = tpti_pkg::PNT_W'(nn - o_ff - tpti_pkg::PT_W'(2));
   assign far_pt   = tpti_pkg::PNT_W'(nn - p_dec - tpti_pkg::PT_W'(1));

   // next state and datapath control
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      k_in         = k_ff;
      pi_in        = pi_ff;
      pj_in        = pj_ff;
      slot_in      = slot_ff;
      value_in     = value_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      dn_in        = dn_ff;
      dk_in        = dk_ff;
      total_in     = total_ff;
      tri_in       = tri_ff;
      rest_in      = rest_ff;
      x_in         = x_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      o_in         = o_ff;
      step_in      = step_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !out_ready;
      in_ready     = (state_ff == tpti_pkg::ST_IDLE);
      tbl_wr_en    = 1'b0;
      tbl_rd_addr  = tpti_pkg::TBL_AW'(mid);
      alu_req.op   = tpti_pkg::ALU_ADD;
      alu_req.a    = '0;
      alu_req.b    = '0;

      unique case (state_ff)
         tpti_pkg::ST_IDLE: begin
            if (in_valid) begin
               op_in    = in_item.opcode;
               k_in     = in_item.linear_index;
               pi_in    = in_item.first_point;
               pj_in    = in_item.second_point;
               slot_in  = in_item.table_slot;
               value_in = in_item.table_value;
               res_in   = '0;
               state_in = tpti_pkg::ST_START;
            end
         end

         // decode the request
         tpti_pkg::ST_START: begin
            if (op_ff != tpti_pkg::OP_WRITE && !n_ok) begin
               res_in.status = tpti_pkg::STAT_RANGE;
               state_in      = tpti_pkg::ST_DONE;
            end else begin
               unique case (op_ff)
                  tpti_pkg::OP_WRITE: begin
                     if (32'(slot_ff) < 32'(tpti_pkg::TABLE_DEPTH)) begin
                        tbl_wr_en = 1'b1;
                     end else begin
                        res_in.status = tpti_pkg::STAT_RANGE;
                     end
                     state_in = tpti_pkg::ST_DONE;
                  end
                  tpti_pkg::OP_PAIR: begin
                     dn_in    = nn;
                     dk_in    = k_ff;
                     state_in = tpti_pkg::ST_TOT;
                  end
                  tpti_pkg::OP_TRIPLE: begin
                     lo_in    = '0;
                     hi_in    = tpti_pkg::IDX_W'(nn - tpti_pkg::PT_W'(2));
                     state_in = tpti_pkg::ST_BS_RD;
                  end
                  tpti_pkg::OP_INDEX: begin
                     if (pi_ff == pj_ff) begin
                        res_in.status = tpti_pkg::STAT_EQUAL;
                        state_in      = tpti_pkg::ST_DONE;
                     end else if (32'(pt_hi) >= 32'(point_count)) begin
                        res_in.status = tpti_pkg::STAT_RANGE;
                        state_in      = tpti_pkg::ST_DONE;
                     end else begin
                        lo_in    = tpti_pkg::IDX_W'(pt_lo);
                        hi_in    = tpti_pkg::IDX_W'(pt_hi);
                        state_in = tpti_pkg::ST_E1;
                     end
                  end
               endcase
            end
         end

         // binary search: issue the table read
         tpti_pkg::ST_BS_RD: begin
            if (lo_ff < hi_ff) begin
               mid_in      = mid;
               tbl_rd_addr = tpti_pkg::TBL_AW'(mid);
               state_in    = tpti_pkg::ST_BS_CMP;
            end else begin
               tbl_rd_addr = (lo_ff == '0) ? '0
                             : tpti_pkg::TBL_AW'(lo_ff - tpti_pkg::IDX_W'(1));
               state_in    = tpti_pkg::ST_BASE;
            end
         end

         // binary search: narrow the range
         tpti_pkg::ST_BS_CMP: begin
            alu_req.op = tpti_pkg::ALU_SUB;
            alu_req.a  = tpti_pkg::ALU_W'(k_ff);
            alu_req.b  = tpti_pkg::ALU_W'(tbl_rd_data);
            if (alu_rsp.neg) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + tpti_pkg::IDX_W'(1);
            end
            state_in = tpti_pkg::ST_BS_RD;
         end

         // offset inside the row of the first point
         tpti_pkg::ST_BASE: begin
            alu_req.op = tpti_pkg::ALU_SUB;
            alu_req.a  = tpti_pkg::ALU_W'(k_ff);
            alu_req.b  = (lo_ff == '0) ? '0 : tpti_pkg::ALU_W'(tbl_rd_data);
            if (alu_rsp.neg) begin
               res_in.status = tpti_pkg::STAT_RANGE;
               state_in      = tpti_pkg::ST_DONE;
            end else begin
               dk_in    = alu_rsp.y[tpti_pkg::DATA_W-1:0];
               dn_in    = nn - tpti_pkg::PT_W'(lo_ff) - tpti_pkg::PT_W'(1);
               state_in = tpti_pkg::ST_TOT;
            end
         end

         // pair count over dn points
         tpti_pkg::ST_TOT: begin
            alu_req.op = tpti_pkg::ALU_TRI;
            alu_req.a  = tpti_pkg::ALU_W'(dn_ff - tpti_pkg::PT_W'(1));
            total_in   = tpti_pkg::PAIR_W'(alu_rsp.y);
            state_in   = tpti_pkg::ST_CHK;
         end

         // pairs counted from the end, range check
         tpti_pkg::ST_CHK: begin
            alu_req.op = tpti_pkg::ALU_SUBB;
            alu_req.a  = tpti_pkg::ALU_W'(total_ff);
            alu_req.b  = tpti_pkg::ALU_W'(dk_ff);
            if (alu_rsp.neg) begin
               res_in.status = tpti_pkg::STAT_RANGE;
               state_in      = tpti_pkg::ST_DONE;
            end else begin
               rest_in  = tpti_pkg::PAIR_W'(alu_rsp.y);
               x_in     = tpti_pkg::SQ_W'({tpti_pkg::PAIR_W'(alu_rsp.y), 3'b001});
               root_in  = '0;
               bit_in   = tpti_pkg::SQ_W'(1) << (tpti_pkg::SQ_W - 2);
               step_in  = '0;
               state_in = tpti_pkg::ST_SQRT;
            end
         end

         // one square root digit per cycle
         tpti_pkg::ST_SQRT: begin
            alu_req.op = tpti_pkg::ALU_SUB;
            alu_req.a  = tpti_pkg::ALU_W'(x_ff);
            alu_req.b  = tpti_pkg::ALU_W'(sq_trial);
            if (!alu_rsp.neg) begin
               x_in    = tpti_pkg::SQ_W'(alu_rsp.y);
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            step_in = step_ff + tpti_pkg::STEP_W'(1);
            if (step_ff == tpti_pkg::STEP_W'(tpti_pkg::SQ_STEPS - 1)) begin
               state_in = tpti_pkg::ST_TRI;
            end
         end

         // row from the end and its triangular count
         tpti_pkg::ST_TRI: begin
            o_in       = o_dec;
            alu_req.op = tpti_pkg::ALU_TRI;
            alu_req.a  = tpti_pkg::ALU_W'(o_dec);
            tri_in     = tpti_pkg::PAIR_W'(alu_rsp.y);
            state_in   = tpti_pkg::ST_PDEC;
         end

         // column from the end, form the points
         tpti_pkg::ST_PDEC: begin
            alu_req.op = tpti_pkg::ALU_SUB;
            alu_req.a  = tpti_pkg::ALU_W'(rest_ff);
            alu_req.b  = tpti_pkg::ALU_W'(tri_ff);
            if (op_ff == tpti_pkg::OP_TRIPLE) begin
               res_in.out_first  = tpti_pkg::PNT_W'(lo_ff);
               res_in.out_second = near_pt;
               res_in.out_third  = far_pt;
            end else begin
               res_in.out_first  = near_pt;
               res_in.out_second = far_pt;
            end
            state_in = tpti_pkg::ST_DONE;
         end

         // pair to index: pairs of n
         tpti_pkg::ST_E1: begin
            alu_req.op = tpti_pkg::ALU_TRI;
            alu_req.a  = tpti_pkg::ALU_W'(nn - tpti_pkg::PT_W'(1));
            total_in   = tpti_pkg::PAIR_W'(alu_rsp.y);
            state_in   = tpti_pkg::ST_E2;
         end

         // pair to index: pairs of n - lo
         tpti_pkg::ST_E2: begin
            alu_req.op = tpti_pkg::ALU_TRI;
            alu_req.a  = tpti_pkg::ALU_W'(nn - tpti_pkg::PT_W'(lo_ff)
                                          - tpti_pkg::PT_W'(1));
            tri_in     = tpti_pkg::PAIR_W'(alu_rsp.y);
            state_in   = tpti_pkg::ST_E3;
         end

         // pair to index: row start minus one
         tpti_pkg::ST_E3: begin
            alu_req.op = tpti_pkg::ALU_SUBB;
            alu_req.a  = tpti_pkg::ALU_W'(total_ff);
            alu_req.b  = tpti_pkg::ALU_W'(tri_ff);
            total_in   = tpti_pkg::PAIR_W'(alu_rsp.y);
            state_in   = tpti_pkg::ST_E4;
         end

         // pair to index: add the column distance, wraps within the pair width
         tpti_pkg::ST_E4: begin
            alu_req.op       = tpti_pkg::ALU_ADD;
            alu_req.a        = tpti_pkg::ALU_W'(total_ff);
            alu_req.b        = tpti_pkg::ALU_W'(hi_ff - lo_ff);
            res_in.out_index = tpti_pkg::DATA_W'(tpti_pkg::PAIR_W'(alu_rsp.y));
            state_in         = tpti_pkg::ST_DONE;
         end

         // hand the result to the output register
         tpti_pkg::ST_DONE: begin
            if (!out_valid_ff || out_ready) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = tpti_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tpti_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpti_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      k_ff     <= k_in;
      pi_ff    <= pi_in;
      pj_ff    <= pj_in;
      slot_ff  <= slot_in;
      value_ff <= value_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      dn_ff    <= dn_in;
      dk_ff    <= dk_in;
      total_ff <= total_in;
      tri_ff   <= tri_in;
      rest_ff  <= rest_in;
      x_ff     <= x_in;
      root_ff  <= root_in;
      bit_ff   <= bit_in;
      o_ff     <= o_in;
      step_ff  <= step_in;
      res_ff   <= res_in;
      out_ff   <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_ff;

   // table writes only come from a write request being decoded
   a_write_src: assert property (@(posedge clock) disable iff (reset)
      tbl_wr_en |-> (state_ff == tpti_pkg::ST_START && op_ff == tpti_pkg::OP_WRITE))
      else $error("table write outside a write request");

   // an accepted request is decoded in the next cycle
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> (state_ff == tpti_pkg::ST_START))
      else $error("accepted request not decoded");

   // equal points status only comes from pair to index
   a_equal_op: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tpti_pkg::ST_DONE && res_ff.status == tpti_pkg::STAT_EQUAL)
      |-> (op_ff == tpti_pkg::OP_INDEX))
      else $error("equal status for wrong opcode");

   // an error result carries zero fields
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tpti_pkg::ST_DONE && res_ff.status != tpti_pkg::STAT_OK)
      |-> (res_ff.out_first == '0 && res_ff.out_second == '0
           && res_ff.out_third == '0 && res_ff.out_index == '0))
      else $error("error result with nonzero fields");

   // the square root never runs past its last digit
   a_sqrt_bit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tpti_pkg::ST_SQRT) |-> (bit_ff != '0))
      else $error("square root step beyond last digit");

endmodule

`default_nettype wire

// ===== hdl/triangular_pair_triple_index_map.sv =====
// top level of the triangular pair/triple index map
//
//   channel  | direction | handshake          | contents
//   req_if   | in        | valid/ready        | opcode, index, pair points, table slot/value
//   rsp_if   | out       | valid/ready        | decoded points, pair index, status
//   csr      | in        | csr_wr_en, no wait | point_count (11 bits)
//
// One request at a time. Index to pair runs eleven square root digits on the
// shared unit; index to triple adds a binary search first (up to 10 steps, each
// a registered table read and a compare on the shared unit).
// Reset is synchronous; point_count returns to 1024, the table is not cleared.
// A held result sits in the output register; the next request is accepted then,
// and its result waits in the sequencer until the output register frees up.
`default_nettype none

module triangular_pair_triple_index_map (
   input  logic                       clock,
   input  logic                       reset,
   tpti_req_if.sink                   req_if,
   tpti_rsp_if.source                 rsp_if,
   input  logic                       csr_wr_en,
   input  logic [tpti_pkg::CFG_W-1:0] csr_wr_data
);

   logic [tpti_pkg::CFG_W-1:0] point_count_ff, point_count_in;
   tpti_pkg::req_type          req_item;
   tpti_pkg::rsp_type          rsp_item;

   // point count register
   always_comb begin
      point_count_in = csr_wr_en ? csr_wr_data : point_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= tpti_pkg::POINT_COUNT_RESET;
      end else begin
         point_count_ff <= point_count_in;
      end
   end

   // request payload
   assign req_item.opcode       = req_if.opcode;
   assign req_item.linear_index = req_if.linear_index;
   assign req_item.first_point  = req_if.first_point;
   assign req_item.second_point = req_if.second_point;
   assign req_item.table_slot   = req_if.table_slot;
   assign req_item.table_value  = req_if.table_value;

   // sequencer
   tpti_core u_core (
      .clock       (clock),
      .reset       (reset),
      .point_count (point_count_ff),
      .in_valid    (req_if.valid),
      .in_ready    (req_if.ready),
      .in_item     (req_item),
      .out_valid   (rsp_if.valid),
      .out_ready   (rsp_if.ready),
      .out_item    (rsp_item)
   );

   // response payload
   assign rsp_if.out_first  = rsp_item.out_first;
   assign rsp_if.out_second = rsp_item.out_second;
   assign rsp_if.out_third  = rsp_item.out_third;
   assign rsp_if.out_index  = rsp_item.out_index;
   assign rsp_if.status     = rsp_item.status;

endmodule

`default_nettype wire
